// ===== rtl/battery_status_led_controller_defines.svh =====
// Assertion macros shared by the battery status LED controller RTL.
// No dependencies; a file that uses a macro must have clk and rst_n in scope.
`ifndef BATTERY_STATUS_LED_CONTROLLER_DEFINES_SVH
`define BATTERY_STATUS_LED_CONTROLLER_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on every rising edge outside reset.
`define BSL_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
// Next-cycle implication, checked on every rising edge outside reset.
`define BSL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define BSL_ASSERT_NOW(lbl, ante, cons)
`define BSL_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/bsl_pkg.sv =====
// Shared types and constants for the battery status LED controller.
// No dependencies; used by the register file, the blinkers and the top level.
`timescale 1ns / 1ps

package bsl_pkg;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam int TICK_W     = 8;
    localparam int CNT_W      = 9;

    // Register indexes, one word apart on the configuration port.
    typedef enum logic [2:0] {
        REG_CHARGE_PERIOD = 3'd0,
        REG_CHARGE_ON     = 3'd1,
        REG_SELF_PERIOD   = 3'd2,
        REG_SELF_ON       = 3'd3,
        REG_EMPTY_PERIOD  = 3'd4,
        REG_EMPTY_ON      = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [TICK_W-1:0] period;
        logic [TICK_W-1:0] on_ticks;
    } blink_cfg_t;

    typedef struct packed {
        blink_cfg_t charge;
        blink_cfg_t self_chg;
        blink_cfg_t empty;
    } bsl_cfg_t;

    localparam logic [TICK_W-1:0] RST_CHARGE_PERIOD = 8'd50;
    localparam logic [TICK_W-1:0] RST_CHARGE_ON     = 8'd25;
    localparam logic [TICK_W-1:0] RST_SELF_PERIOD   = 8'd50;
    localparam logic [TICK_W-1:0] RST_SELF_ON       = 8'd10;
    localparam logic [TICK_W-1:0] RST_EMPTY_PERIOD  = 8'd100;
    localparam logic [TICK_W-1:0] RST_EMPTY_ON      = 8'd20;

    localparam logic [1:0] LEVEL_EMPTY = 2'd0;
    localparam logic [1:0] LEVEL_FULL  = 2'd3;

    localparam logic [7:0] POWER_BIT  = 8'b0000_0001;
    localparam logic [7:0] CHARGE_BIT = 8'b0000_0010;
    localparam logic [7:0] EMPTY_BIT  = 8'b0010_0000;
    localparam logic [7:0] BAR_MASK   = 8'b1110_0000;

endpackage

// ===== rtl/bsl_cfg_regs.sv =====
// Configuration register file for the battery status LED controller.
// Depends on bsl_pkg for the register indexes and the configuration struct.
`timescale 1ns / 1ps

module bsl_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bsl_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [bsl_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [bsl_pkg::CFG_DATA_W-1:0] prdata,
    output bsl_pkg::bsl_cfg_t              cfg
);
    import bsl_pkg::*;

    bsl_cfg_t          cfg_reg;
    bsl_cfg_t          cfg_next;
    reg_idx_t          idx;
    logic              wr_en;
    logic [TICK_W-1:0] wr_val;
    logic [TICK_W-1:0] rd_val;

    assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
    assign wr_en  = psel & penable & pwrite;
    assign wr_val = pwdata[TICK_W-1:0];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_CHARGE_PERIOD: cfg_next.charge.period     = wr_val;
                REG_CHARGE_ON:     cfg_next.charge.on_ticks   = wr_val;
                REG_SELF_PERIOD:   cfg_next.self_chg.period   = wr_val;
                REG_SELF_ON:       cfg_next.self_chg.on_ticks = wr_val;
                REG_EMPTY_PERIOD:  cfg_next.empty.period      = wr_val;
                REG_EMPTY_ON:      cfg_next.empty.on_ticks    = wr_val;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_CHARGE_PERIOD: rd_val = cfg_reg.charge.period;
            REG_CHARGE_ON:     rd_val = cfg_reg.charge.on_ticks;
            REG_SELF_PERIOD:   rd_val = cfg_reg.self_chg.period;
            REG_SELF_ON:       rd_val = cfg_reg.self_chg.on_ticks;
            REG_EMPTY_PERIOD:  rd_val = cfg_reg.empty.period;
            REG_EMPTY_ON:      rd_val = cfg_reg.empty.on_ticks;
            default:           rd_val = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.charge.period     <= RST_CHARGE_PERIOD;
            cfg_reg.charge.on_ticks   <= RST_CHARGE_ON;
            cfg_reg.self_chg.period   <= RST_SELF_PERIOD;
            cfg_reg.self_chg.on_ticks <= RST_SELF_ON;
            cfg_reg.empty.period      <= RST_EMPTY_PERIOD;
            cfg_reg.empty.on_ticks    <= RST_EMPTY_ON;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign prdata = {{(CFG_DATA_W-TICK_W){1'b0}}, rd_val};
    assign cfg    = cfg_reg;

endmodule

// ===== rtl/bsl_blinker.sv =====
// One tick-counting blinker: LED state and a 9-bit tick counter.
// Depends on bsl_pkg for the blinker configuration struct and widths.
`timescale 1ns / 1ps

module bsl_blinker (
    input  logic                clk,
    input  logic                rst_n,
    input  bsl_pkg::blink_cfg_t cfg,
    input  logic                active,
    input  logic                step,
    output logic                led
);
    import bsl_pkg::*;

    logic             led_reg;
    logic             led_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [CNT_W-1:0] cnt_held;
    logic             past_on;
    logic             past_period;

    assign past_on     = cnt_reg >= {1'b0, cfg.on_ticks};
    assign past_period = cnt_reg >= {1'b0, cfg.period};

    // An idle blinker parks its counter one past the period so it lights at once
    // on the first active tick.
    always_comb
    begin
        led_next = led_reg;
        cnt_held = cnt_reg;
        if (active)
        begin
            if (past_on)
            begin
                led_next = 1'b0;
            end
            if (past_period)
            begin
                led_next = 1'b1;
                cnt_held = '0;
            end
        end
        else
        begin
            led_next = 1'b0;
            cnt_held = {1'b0, cfg.period};
        end
        cnt_next = cnt_held + CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (step)
        begin
            led_reg <= led_next;
            cnt_reg <= cnt_next;
        end
    end

    assign led = led_next;

endmodule

// ===== rtl/battery_status_led_controller.sv =====
// A result appears in the cycle after its tick transfer; throughput is one tick per cycle while out_ready keeps up.
// The only path is the tick inputs plus three blinker counters into the output register.
// A new tick is taken while the output register is empty or its result is taken that cycle.
// Reset (rst_n, asynchronous, active low) clears the blinker LEDs and counters and the
// output valid flag, and loads the register defaults 50/25, 50/10 and 100/20.
// Top level of the battery status LED controller; uses bsl_pkg, bsl_cfg_regs and bsl_blinker.
`timescale 1ns / 1ps

`include "battery_status_led_controller_defines.svh"

module battery_status_led_controller (
    input  logic                           clk,
    input  logic                           rst_n,
    // Configuration port.
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bsl_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [bsl_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [bsl_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    // Tick channel.
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           power_switch,
    input  logic                           charging_other,
    input  logic                           charging_self,
    input  logic [1:0]                     battery_level,
    // LED pattern channel.
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [7:0]                     led_pattern
);
    import bsl_pkg::*;

    bsl_cfg_t   cfg;
    logic       in_xfer;
    logic       charge_active;
    logic       self_active;
    logic       empty_active;
    logic       charge_led;
    logic       self_led;
    logic       empty_led;
    logic       steady;
    logic [7:0] bar;
    logic [7:0] pattern_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] led_pattern_reg;

    // Register writes complete in the access phase without wait states.
    assign pready = 1'b1;

    bsl_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // The output register doubles as the skid stage: a tick transfer is taken
    // whenever the held result is gone or leaves in this same cycle.
    assign in_ready = !out_valid_reg || out_ready;
    assign in_xfer  = in_valid && in_ready;

    // Blinker enables for the current tick.
    assign charge_active = power_switch && charging_other;
    assign self_active   = charging_self && (battery_level != LEVEL_FULL);
    assign empty_active  = power_switch && (battery_level == LEVEL_EMPTY);

    // Each blinker advances its counter only on an accepted tick, so stalls
    // on either side do not disturb the blink timing.
    bsl_blinker u_charge_blinker (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg.charge),
        .active (charge_active),
        .step   (in_xfer),
        .led    (charge_led)
    );

    bsl_blinker u_self_blinker (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg.self_chg),
        .active (self_active),
        .step   (in_xfer),
        .led    (self_led)
    );

    bsl_blinker u_empty_blinker (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg.empty),
        .active (empty_active),
        .step   (in_xfer),
        .led    (empty_led)
    );

    // The level bar fills from bit 5 upward, one segment per level step,
    // and is dark while the power switch is off.
    always_comb
    begin
        case (battery_level)
            2'd0:    bar = 8'b0000_0000;
            2'd1:    bar = 8'b0010_0000;
            2'd2:    bar = 8'b0110_0000;
            default: bar = BAR_MASK;
        endcase
        if (!power_switch)
        begin
            bar = '0;
        end
    end

    // While the bank charges itself the steady power LED shows only a full
    // battery; below full the self-charge blinker takes over bit 0.
    assign steady = charging_self ? (battery_level == LEVEL_FULL) : power_switch;

    always_comb
    begin
        pattern_next = bar;
        if (steady || self_led)
        begin
            pattern_next = pattern_next | POWER_BIT;
        end
        if (charge_led)
        begin
            pattern_next = pattern_next | CHARGE_BIT;
        end
        if (empty_led)
        begin
            pattern_next = pattern_next | EMPTY_BIT;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_xfer)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // The pattern register carries no reset; out_valid qualifies it.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            led_pattern_reg <= pattern_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign led_pattern = led_pattern_reg;

    // Every accepted tick leaves a result waiting in the next cycle.
    `BSL_ASSERT_NEXT(a_result_follows_tick, in_xfer, out_valid)
    // A result that is still waiting must block the next tick.
    `BSL_ASSERT_NOW(a_no_overwrite, out_valid && !out_ready, !in_ready)
    // With the power switch off, the whole bar including the empty warning is dark.
    `BSL_ASSERT_NEXT(a_bar_dark_when_off, in_xfer && !power_switch,
        led_pattern[7:5] == 3'b000)
    // Self charging at full level lights the power LED steadily.
    `BSL_ASSERT_NEXT(a_full_self_charge_lit,
        in_xfer && charging_self && (battery_level == LEVEL_FULL), led_pattern[0])

endmodule
